/* sv/qee_pkg.sv */
// Shared types, field widths and opcodes of the QUBO energy evaluator.
`timescale 1ns / 1ps

package qee_pkg;

   localparam int COEFF_W  = 32;  // Q16.16 coefficient
   localparam int CAND_W   = 18;  // candidate bit vector
   localparam int ENERGY_W = 40;  // Q24.16 energy
   localparam int OP_W     = 2;
   localparam int IDX_W    = 5;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [IDX_W-1:0]          row_index;
      logic [IDX_W-1:0]          col_index;
      logic signed [COEFF_W-1:0] coeff_value;
      logic [CAND_W-1:0]         candidate;
   } req_payload_type;

   typedef struct packed {
      logic signed [ENERGY_W-1:0] energy;
      logic [CAND_W-1:0]          candidate_echo;
   } rsp_payload_type;

   typedef logic signed [COEFF_W-1:0] csr_payload_type;

   // Travels with each coefficient row through the summing pipeline.
   typedef struct packed {
      logic valid;
      logic last;
      logic row_en;
   } row_tag_type;

endpackage

/* sv/qee_stream_if.sv */
// Valid/ready channel with a typed payload.
`timescale 1ns / 1ps

interface qee_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/qee_coeff_mem.sv */
// Coefficient row memory: one matrix row per word, per-row valid bits.
`timescale 1ns / 1ps

module qee_coeff_mem import qee_pkg::*; #(
   parameter int NUM_VARS = 18,
   localparam int RIDX_W = $clog2(NUM_VARS),
   localparam int ROW_BITS = NUM_VARS * COEFF_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [RIDX_W-1:0]   rd_addr,
   output logic [ROW_BITS-1:0] rd_data,
   input  logic                wr_en,
   input  logic [RIDX_W-1:0]   wr_addr,
   input  logic [ROW_BITS-1:0] wr_data
);

   logic [ROW_BITS-1:0] mem [NUM_VARS];
   logic [ROW_BITS-1:0] rd_q_ff;
   logic                rd_vld_ff;
   logic [NUM_VARS-1:0] row_vld_ff;
   logic [NUM_VARS-1:0] row_vld_in;

   always_comb begin
      row_vld_in = row_vld_ff;
      if (wr_en) begin
         row_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         row_vld_ff <= row_vld_in;
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // a row never written reads as all zeros
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

/* sv/qee_row_adder.sv */
// Masked row sum: groups of four in the first stage, groups combined in the second.
`timescale 1ns / 1ps

module qee_row_adder import qee_pkg::*; #(
   parameter int NUM_VARS = 18,
   parameter int ROW_W = 38,
   localparam int ROW_BITS = NUM_VARS * COEFF_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  row_tag_type              in_tag,
   input  logic [ROW_BITS-1:0]      in_row,
   input  logic [NUM_VARS-1:0]      var_set,
   output row_tag_type              out_tag,
   output logic signed [ROW_W-1:0]  out_sum
);

   localparam int GRP_SIZE = 4;
   localparam int NUM_GRPS = (NUM_VARS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_W    = COEFF_W + $clog2(GRP_SIZE);

   logic [NUM_VARS-1:0]     mask;
   logic signed [GRP_W-1:0] grp_in [NUM_GRPS];
   logic signed [GRP_W-1:0] grp_ff [NUM_GRPS];
   row_tag_type             tag1_ff;
   row_tag_type             tag2_ff;
   logic signed [ROW_W-1:0] sum_in;
   logic signed [ROW_W-1:0] sum_ff;

   assign mask = in_tag.row_en ? var_set : '0;

   always_comb begin
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < NUM_VARS) begin
               if (mask[g * GRP_SIZE + k]) begin
                  grp_in[g] = grp_in[g]
                     + GRP_W'($signed(in_row[(g * GRP_SIZE + k) * COEFF_W +: COEFF_W]));
               end
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NUM_GRPS; g++) begin
         sum_in = sum_in + ROW_W'(grp_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
      sum_ff <= sum_in;
   end

   assign out_tag = tag2_ff;
   assign out_sum = sum_ff;

endmodule

/* sv/qee_sequencer.sv */
// Control: coefficient read-modify-write, row sweep, accumulation and result register.
`timescale 1ns / 1ps

module qee_sequencer import qee_pkg::*; #(
   parameter int NUM_VARS = 18,
   parameter int ROW_W = 38,
   localparam int RIDX_W = $clog2(NUM_VARS),
   localparam int ROW_BITS = NUM_VARS * COEFF_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_data,
   input  logic signed [COEFF_W-1:0] energy_offset,
   output logic                      mem_rd_en,
   output logic [RIDX_W-1:0]         mem_rd_addr,
   input  logic [ROW_BITS-1:0]       mem_rd_data,
   output logic                      mem_wr_en,
   output logic [RIDX_W-1:0]         mem_wr_addr,
   output logic [ROW_BITS-1:0]       mem_wr_data,
   output logic [NUM_VARS-1:0]       var_set,
   output row_tag_type               row_tag,
   input  row_tag_type               sum_tag,
   input  logic signed [ROW_W-1:0]   row_sum
);

   localparam int ACC_W = COEFF_W + $clog2(NUM_VARS * (NUM_VARS + 1) / 2 + 1) + 1;
   localparam int EXT_W = ((ACC_W > ENERGY_W) ? ACC_W : ENERGY_W) + 1;
   localparam logic signed [EXT_W-1:0] E_MAX = (EXT_W'(1) <<< (ENERGY_W - 1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] E_MIN = ~E_MAX;
   localparam logic [RIDX_W-1:0] LAST_ROW = RIDX_W'(NUM_VARS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [RIDX_W-1:0]         row_ff, row_in;
   logic [RIDX_W-1:0]         col_ff, col_in;
   logic                      add_ff, add_in;
   logic signed [COEFF_W-1:0] val_ff, val_in;
   logic [CAND_W-1:0]         cand_ff, cand_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   row_tag_type               tag_ff, tag_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      idx_ok;
   logic signed [COEFF_W-1:0] old_coeff;
   logic signed [COEFF_W:0]   add_sum;
   logic signed [COEFF_W-1:0] new_coeff;
   logic signed [EXT_W-1:0]   acc_ext;
   logic signed [EXT_W-1:0]   sat_ext;

   // variable i sits at candidate bit NUM_VARS-1-i; bits above the field read as zero
   for (genvar i = 0; i < NUM_VARS; i++) begin : g_var
      if (NUM_VARS - 1 - i < CAND_W) begin : g_in
         assign var_set[i] = cand_ff[NUM_VARS - 1 - i];
      end else begin : g_out
         assign var_set[i] = 1'b0;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_ok    = (int'(req_data.row_index) < NUM_VARS)
                   && (int'(req_data.col_index) < NUM_VARS)
                   && (req_data.row_index <= req_data.col_index);

   // entry update with 32-bit saturation on add
   always_comb begin
      old_coeff = $signed(mem_rd_data[col_ff * COEFF_W +: COEFF_W]);
      add_sum   = (COEFF_W + 1)'(old_coeff) + (COEFF_W + 1)'(val_ff);
      if (!add_ff) begin
         new_coeff = val_ff;
      end else if (add_sum[COEFF_W] != add_sum[COEFF_W-1]) begin
         new_coeff = add_sum[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}}
                                      : {1'b0, {(COEFF_W-1){1'b1}}};
      end else begin
         new_coeff = add_sum[COEFF_W-1:0];
      end
      mem_wr_data = mem_rd_data;
      mem_wr_data[col_ff * COEFF_W +: COEFF_W] = new_coeff;
   end

   assign mem_wr_addr = row_ff;

   always_comb begin
      acc_ext = EXT_W'(acc_ff);
      priority if (acc_ext > E_MAX) begin
         sat_ext = E_MAX;
      end else if (acc_ext < E_MIN) begin
         sat_ext = E_MIN;
      end else begin
         sat_ext = acc_ext;
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      add_in       = add_ff;
      val_in       = val_ff;
      cand_in      = cand_ff;
      acc_in       = acc_ff;
      tag_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = row_ff;
      mem_wr_en    = 1'b0;

      if (sum_tag.valid) begin
         acc_in = acc_ff + ACC_W'(row_sum);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_EVAL) begin
                  cand_in  = req_data.candidate;
                  acc_in   = ACC_W'(energy_offset);
                  row_in   = '0;
                  state_in = ST_ISSUE;
               end else if ((req_data.op == OP_WRITE || req_data.op == OP_ADD) && idx_ok) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_data.row_index[RIDX_W-1:0];
                  row_in      = req_data.row_index[RIDX_W-1:0];
                  col_in      = req_data.col_index[RIDX_W-1:0];
                  add_in      = (req_data.op == OP_ADD);
                  val_in      = req_data.coeff_value;
                  state_in    = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            mem_wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_ISSUE: begin
            mem_rd_en     = 1'b1;
            tag_in.valid  = 1'b1;
            tag_in.row_en = var_set[row_ff];
            tag_in.last   = (row_ff == LAST_ROW);
            if (row_ff == LAST_ROW) begin
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + RIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (sum_tag.valid && sum_tag.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.energy         = sat_ext[ENERGY_W-1:0];
               rsp_data_in.candidate_echo = cand_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      add_ff      <= add_in;
      val_ff      <= val_in;
      cand_ff     <= cand_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign row_tag   = tag_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/qubo_energy_evaluator_top.sv */
// Top level of the QUBO energy evaluator.
//
//   channel   dir  payload                                             transaction
//   req_chan  in   op, row_index, col_index, coeff_value, candidate    valid & ready
//   rsp_chan  out  energy, candidate_echo                              valid & ready
//   csr_chan  in   energy_offset (signed Q16.16)                       valid & ready
//
// Write/add: row read, then modified row written back, before req ready returns.
// Evaluate: req ready returns once the energy is in the output register. The
//   coefficient memory delivers one row per cycle, then the two-stage row adder and
//   the final accumulate/saturate drain.
// Reset clears the per-row valid bits at once; no clearing sweep is needed.
// A finished energy waits in the output register while new transactions are accepted;
//   a later evaluate holds in its last state only if that register is still full.
// csr_chan is always ready.
`timescale 1ns / 1ps

module qubo_energy_evaluator_top import qee_pkg::*; #(
   parameter int NUM_VARS = 18
) (
   input logic           clock,
   input logic           reset,
   qee_stream_if.sink    req_chan,
   qee_stream_if.source  rsp_chan,
   qee_stream_if.sink    csr_chan
);

   localparam int RIDX_W   = $clog2(NUM_VARS);
   localparam int ROW_BITS = NUM_VARS * COEFF_W;
   // sum of one masked row of NUM_VARS signed coefficients
   localparam int ROW_W    = COEFF_W + $clog2(NUM_VARS) + 1;

   logic signed [COEFF_W-1:0] offset_ff;

   logic                      mem_rd_en;
   logic [RIDX_W-1:0]         mem_rd_addr;
   logic [ROW_BITS-1:0]       mem_rd_data;
   logic                      mem_wr_en;
   logic [RIDX_W-1:0]         mem_wr_addr;
   logic [ROW_BITS-1:0]       mem_wr_data;
   logic [NUM_VARS-1:0]       var_set;
   row_tag_type               row_tag;
   row_tag_type               sum_tag;
   logic signed [ROW_W-1:0]   row_sum;

   // energy offset register; the user must write it only while the block is idle (not enforced)
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_chan.valid) begin
         offset_ff <= csr_chan.data;
      end
   end

   // Sequencer: owns the handshakes. The FSM never issues a read while a write-back
   // is pending, so the memory needs no forwarding path.
   qee_sequencer #(
      .NUM_VARS (NUM_VARS),
      .ROW_W    (ROW_W)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_data      (req_chan.data),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_data      (rsp_chan.data),
      .energy_offset (offset_ff),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .var_set       (var_set),
      .row_tag       (row_tag),
      .sum_tag       (sum_tag),
      .row_sum       (row_sum)
   );

   // Coefficient store: row r holds Q[r][0..NUM_VARS-1], one 32-bit slot each.
   qee_coeff_mem #(
      .NUM_VARS (NUM_VARS)
   ) u_coeff_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Row sum: entries masked by the candidate bits; lower triangle is always zero.
   qee_row_adder #(
      .NUM_VARS (NUM_VARS),
      .ROW_W    (ROW_W)
   ) u_row_adder (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (row_tag),
      .in_row  (mem_rd_data),
      .var_set (var_set),
      .out_tag (sum_tag),
      .out_sum (row_sum)
   );

endmodule

/* sv/qee_checker.sv */
// Port-level checks for the QUBO energy evaluator, bound to the top level.
`timescale 1ns / 1ps

module qee_checker import qee_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [OP_W-1:0]     req_op,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ENERGY_W-1:0] rsp_energy,
   input logic [CAND_W-1:0]   rsp_cand
);

   // a pending result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_energy) && $stable(rsp_cand)))
      else $error("result changed while stalled");

   // an evaluate occupies the block: no transaction in the following cycle
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_EVAL) |=> !req_ready)
      else $error("request taken right after an evaluate");

   // a new result only appears at the end of an evaluate, never from idle
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while idle");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind qubo_energy_evaluator_top qee_checker u_qee_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_op     (req_chan.data.op),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_energy (rsp_chan.data.energy),
   .rsp_cand   (rsp_chan.data.candidate_echo)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the QUBO energy evaluator: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
   import qee_pkg::*;

   localparam int NV           = 18;
   localparam int DRAIN_CYCLES = NV + 8;        // evaluate latency plus margin
   localparam longint LIMIT_NS = 5_000_000;     // watchdog, far above the slowest run

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
   localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};
   localparam longint E_MAX = (longint'(1) <<< (ENERGY_W-1)) - 1;
   localparam longint E_MIN = -(longint'(1) <<< (ENERGY_W-1));
   localparam longint C_MAX = (longint'(1) <<< (COEFF_W-1)) - 1;
   localparam longint C_MIN = -(longint'(1) <<< (COEFF_W-1));

   logic clock;
   logic reset;

   qee_stream_if #(.payload_type(req_payload_type)) req_if ();
   qee_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();
   qee_stream_if #(.payload_type(csr_payload_type)) csr_if ();

   qubo_energy_evaluator_top #(.NUM_VARS(NV)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Shadow copy of the coefficient matrix and the offset register
   logic signed [COEFF_W-1:0] model_coeff [NV][NV];
   csr_payload_type           model_offset;
   rsp_payload_type           pending_energies [$];

   int send_idle_pct;
   int recv_stall_pct;
   int sent_count;
   int checked_count;
   int offset_count;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_top: errors");
      $finish;
   end

   // Receiver back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(string msg);
      if (mismatch_count < 60) begin
         $display("mismatch @%0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic logic [CAND_W-1:0] var_mask(int i);
      logic [CAND_W-1:0] m;
      m = '0;
      if (NV - 1 - i < CAND_W) begin
         m[NV-1-i] = 1'b1;
      end
      return m;
   endfunction

   function automatic bit var_set(logic [CAND_W-1:0] cand, int i);
      int pos;
      pos = NV - 1 - i;
      return (pos < CAND_W) && cand[pos];
   endfunction

   function automatic logic signed [ENERGY_W-1:0] compute_energy(logic [CAND_W-1:0] cand);
      longint acc;
      acc = longint'(model_offset);
      for (int i = 0; i < NV; i++) begin
         if (var_set(cand, i)) begin
            for (int j = i; j < NV; j++) begin
               if (var_set(cand, j)) begin
                  acc += longint'(model_coeff[i][j]);
               end
            end
         end
      end
      if (acc > E_MAX) begin
         acc = E_MAX;
      end else if (acc < E_MIN) begin
         acc = E_MIN;
      end
      return acc[ENERGY_W-1:0];
   endfunction

   // Apply one accepted request transaction to the shadow state
   task automatic predict_req(req_payload_type item);
      longint s;
      rsp_payload_type exp_rsp;
      if ((item.op == OP_WRITE || item.op == OP_ADD) && item.row_index < NV &&
          item.col_index < NV && item.row_index <= item.col_index) begin
         if (item.op == OP_WRITE) begin
            model_coeff[item.row_index][item.col_index] = item.coeff_value;
         end else begin
            s = longint'(model_coeff[item.row_index][item.col_index]) +
                longint'(item.coeff_value);
            if (s > C_MAX) begin
               s = C_MAX;
            end else if (s < C_MIN) begin
               s = C_MIN;
            end
            model_coeff[item.row_index][item.col_index] = s[COEFF_W-1:0];
         end
      end else if (item.op == OP_EVAL) begin
         exp_rsp.energy         = compute_energy(item.candidate);
         exp_rsp.candidate_echo = item.candidate;
         pending_energies.push_back(exp_rsp);
      end
   endtask

   // Leaves valid high after the accept; the next send or release_req settles it
   task automatic send_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic signed [COEFF_W-1:0] coeff, logic [CAND_W-1:0] cand);
      req_payload_type item;
      item.op          = op;
      item.row_index   = row;
      item.col_index   = col;
      item.coeff_value = coeff;
      item.candidate   = cand;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         req_if.data  <= req_payload_type'($urandom());
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      predict_req(item);
      sent_count++;
   endtask

   task automatic send_eval(logic [CAND_W-1:0] cand);
      send_req(OP_EVAL, IDX_W'($urandom()), IDX_W'($urandom()), COEFF_W'($urandom()), cand);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Block idle: every energy delivered and any write/add finished inside
   task automatic wait_drained();
      release_req();
      while (pending_energies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(csr_payload_type value);
      wait_drained();
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      model_offset = value;
      offset_count++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (pending_energies.size() == 0) begin
            report_mismatch($sformatf("unexpected energy %0d for candidate %h",
                                      got.energy, got.candidate_echo));
         end else begin
            want = pending_energies.pop_front();
            checked_count++;
            if (got.energy !== want.energy) begin
               report_mismatch($sformatf("energy for candidate %h: got %0d, want %0d",
                                         want.candidate_echo, got.energy, want.energy));
            end
            if (got.candidate_echo !== want.candidate_echo) begin
               report_mismatch($sformatf("candidate echo: got %h, want %h",
                                         got.candidate_echo, want.candidate_echo));
            end
         end
      end
   end

   function automatic logic signed [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(0, 9))
         0:       return COEFF_MAX;
         1:       return COEFF_MIN;
         2, 3, 4: return COEFF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return COEFF_W'($urandom());
      endcase
   endfunction

   function automatic logic [CAND_W-1:0] rand_cand();
      if ($urandom_range(0, 3) == 0) begin
         return var_mask($urandom_range(0, NV - 1)) | var_mask($urandom_range(0, NV - 1));
      end
      return CAND_W'($urandom());
   endfunction

   // ---- tests ----

   task automatic test_cleared_matrix();
      send_eval('1);
      send_eval('0);
   endtask

   task automatic test_coeff_extremes();
      send_req(OP_WRITE, IDX_W'(0), IDX_W'(0), COEFF_MAX, '0);
      send_req(OP_WRITE, IDX_W'(NV - 1), IDX_W'(NV - 1), COEFF_MIN, '1);
      send_req(OP_WRITE, IDX_W'(0), IDX_W'(NV - 1), -1, '0);
      send_req(OP_WRITE, IDX_W'(3), IDX_W'(9), 32'sh0001_0000, '0);
      send_eval(var_mask(0));
      send_eval(var_mask(NV - 1));
      send_eval(var_mask(0) | var_mask(NV - 1));
      send_eval(var_mask(3) | var_mask(9));
      send_eval('1);
   endtask

   task automatic test_add_saturation();
      send_req(OP_ADD, IDX_W'(0), IDX_W'(0), COEFF_MAX, '0);           // clips high
      send_req(OP_WRITE, IDX_W'(5), IDX_W'(5), COEFF_MIN + 5, '0);
      send_req(OP_ADD, IDX_W'(5), IDX_W'(5), -10, '0);                 // clips low
      send_eval(var_mask(0));
      send_eval(var_mask(5));
   endtask

   task automatic test_ignored_items();
      send_req(OP_WRITE, IDX_W'(9), IDX_W'(4), COEFF_MAX, '0);         // lower triangle
      send_req(OP_ADD, IDX_W'(9), IDX_W'(4), COEFF_MAX, '0);
      send_req(OP_WRITE, IDX_W'(NV), IDX_W'(NV), COEFF_MAX, '0);       // row/col out of range
      send_req(OP_WRITE, IDX_W'(2), IDX_W'(31), COEFF_MAX, '0);
      send_req(OP_ADD, IDX_W'(31), IDX_W'(31), COEFF_MIN, '1);
      send_req(OP_UNUSED, IDX_W'(1), IDX_W'(1), COEFF_MAX, '1);        // unused op, no result
      send_eval('1);
   endtask

   task automatic test_offset_extremes();
      write_offset(COEFF_MIN);
      send_eval('1);
      send_eval('0);
      write_offset(COEFF_MAX);
      send_eval('1);
      send_eval('0);
      write_offset('0);
      send_eval(18'h2AAAA);
   endtask

   task automatic test_random_traffic(int n_items, int sender_pct, int receiver_pct);
      int pause_at;
      int kind;
      int r;
      csr_payload_type offs;
      case ($urandom_range(0, 3))
         0:       offs = COEFF_MIN;
         1:       offs = COEFF_MAX;
         2:       offs = COEFF_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: offs = COEFF_W'($urandom());
      endcase
      write_offset(offs);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      pause_at = $urandom_range(10, n_items - 10);
      for (int k = 0; k < n_items; k++) begin
         if (k == pause_at) begin
            wait_drained();                            // sender holds until all energies are in
         end
         kind = $urandom_range(0, 99);
         r = $urandom_range(0, NV - 1);
         if (kind < 40) begin
            send_eval(rand_cand());
         end else if (kind < 65) begin
            send_req(OP_WRITE, IDX_W'(r), IDX_W'($urandom_range(r, NV - 1)), rand_coeff(),
                     CAND_W'($urandom()));
         end else if (kind < 85) begin
            send_req(OP_ADD, IDX_W'(r), IDX_W'($urandom_range(r, NV - 1)), rand_coeff(),
                     CAND_W'($urandom()));
         end else begin
            send_req(OP_W'($urandom_range(0, 3)), IDX_W'($urandom()), IDX_W'($urandom()),
                     rand_coeff(), CAND_W'($urandom()));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sent_count     = 0;
      checked_count  = 0;
      offset_count   = 0;
      mismatch_count = 0;
      model_offset   = '0;
      for (int i = 0; i < NV; i++) begin
         for (int j = 0; j < NV; j++) begin
            model_coeff[i][j] = '0;
         end
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct  = 9;
      recv_stall_pct = 76;
      test_cleared_matrix();
      test_coeff_extremes();
      test_add_saturation();
      test_ignored_items();
      test_offset_extremes();
      test_random_traffic(205, 9, 76);
      test_random_traffic(205, 76, 9);
      test_random_traffic(205, 0, 0);

      wait_drained();
      if (pending_energies.size() != 0) begin
         report_mismatch($sformatf("%0d energies never arrived", pending_energies.size()));
      end
      $display("summary: %0d request transactions, %0d energies compared, %0d offset writes",
               sent_count, checked_count, offset_count);
      $display("summary: three back-pressure mixes, saturation and ignored cases, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* qubo_energy_evaluator_top.f */
sv/qee_pkg.sv
sv/qee_stream_if.sv
sv/qee_coeff_mem.sv
sv/qee_row_adder.sv
sv/qee_sequencer.sv
sv/qubo_energy_evaluator_top.sv
sv/qee_checker.sv
tb/sv/tb_top.sv
